>>> src/bq_pkg.sv
package bq_pkg;

  localparam int SMP_W = 32;
  localparam int PRD_W = 64;
  localparam int FRC_W = 33;
  localparam int ACC_W = 35;
  localparam int SLOTS = 5;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic signed [FRC_W-1:0] frc_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    SLOT_A1 = 3'd0,
    SLOT_A2 = 3'd1,
    SLOT_B0 = 3'd2,
    SLOT_B1 = 3'd3,
    SLOT_B2 = 3'd4
  } coef_slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_B0,
    ST_ACC
  } cell_state_t;

  typedef struct packed {
    logic       en;
    coef_slot_t slot;
    smp_t       value;
  } coef_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cell_stat_t;

  localparam acc_t SAT_HI = 35'sh0_7FFF_FFFF;
  localparam acc_t SAT_LO = -35'sh0_8000_0000;

  // floor shift by 31 of the exact product is its top 33 bits
  function automatic frc_t frac_q31(input prd_t p);
    return $signed(p[PRD_W-1:PRD_W-FRC_W]);
  endfunction

  function automatic acc_t ext_smp(input smp_t v);
    return {{(ACC_W-SMP_W){v[SMP_W-1]}}, v};
  endfunction

  function automatic acc_t ext_frc(input frc_t v);
    return {{(ACC_W-FRC_W){v[FRC_W-1]}}, v};
  endfunction

  function automatic smp_t sat32(input acc_t v);
    smp_t r;
    if (v > SAT_HI) r = {1'b0, {(SMP_W-1){1'b1}}};
    else if (v < SAT_LO) r = {1'b1, {(SMP_W-1){1'b0}}};
    else r = v[SMP_W-1:0];
    return r;
  endfunction

endpackage

>>> src/bq_cell.sv
module bq_cell import bq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  coef_wr_t   coef_wr,
  input  logic       start,
  input  smp_t       x,
  output smp_t       y,
  output cell_stat_t stat
);

  cell_state_t state_r, state_nxt;
  smp_t coef_r [SLOTS];
  smp_t w1_r, w2_r, w0_r, x_r, y_r;
  prd_t prod_r;
  acc_t acc_r;
  logic done_r;
  smp_t mul_a, mul_b;
  frc_t frc;

  assign frc = frac_q31(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mul_a = coef_r[SLOT_A1];
    mul_b = w1_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_A2;
      end
      ST_A2: begin
        mul_a = coef_r[SLOT_A2];
        mul_b = w2_r;
        state_nxt = ST_B1;
      end
      ST_B1: begin
        mul_a = coef_r[SLOT_B1];
        mul_b = w1_r;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        mul_a = coef_r[SLOT_B2];
        mul_b = w2_r;
        state_nxt = ST_B0;
      end
      ST_B0: begin
        mul_a = coef_r[SLOT_B0];
        mul_b = w0_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: if (start) x_r <= x;
      ST_A2:   acc_r <= ext_smp(x_r) - ext_frc(frc);
      ST_B1:   w0_r  <= sat32(acc_r - ext_frc(frc));
      ST_B2:   acc_r <= ext_frc(frc);
      ST_B0:   acc_r <= acc_r + ext_frc(frc);
      ST_ACC:  y_r   <= sat32(acc_r + ext_frc(frc));
      default: acc_r <= acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r   <= '0;
      w2_r   <= '0;
      done_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) coef_r[k] <= '0;
    end else begin
      done_r <= (state_r == ST_ACC);
      if (state_r == ST_ACC) begin
        w2_r <= w1_r;
        w1_r <= w0_r;
      end
      if (coef_wr.en) coef_r[coef_wr.slot] <= coef_wr.value;
    end
  end

  assign y         = y_r;
  assign stat.done = done_r;
  assign stat.busy = (state_r != ST_IDLE);

endmodule

>>> src/biquad_cascade_q31.sv
// Cascade of up to MAX_SECTIONS direct form II biquads on signed Q31 samples.
// An item with in_func 0 filters in_sample_in through the first section_count
// sections (0 is taken as 1, anything above MAX_SECTIONS as MAX_SECTIONS) and
// yields one saturated out_sample_out; an item with in_func 1 writes the
// coefficient word in_coef_index (section*5 + slot a1,a2,b0,b1,b2) and
// yields nothing. Each section is a cell with its own coefficients, delays
// and one 32x32 multiplier shared over its five products; the active sections
// run one after another, each starting when the one before it is done. One
// sample is in the chain at a time; the input stalls from its transfer until
// its result is registered, and also while a second result waits behind a
// stalled output.
// Coefficients and delays reset to zero, section_count to 1.
module biquad_cascade_q31 import bq_pkg::*; #(
  parameter int MAX_SECTIONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_coef_index,
  input  smp_t        in_coef_value,
  input  smp_t        in_sample_in,
  output logic        out_valid,
  input  logic        out_stall,
  output smp_t        out_sample_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic [2:0]       section_count_r;
  logic [SEC_W-1:0] last_idx;
  logic             in_xfer, out_xfer, fin;
  logic             busy_r, out_valid_r, pend_valid_r;
  smp_t             out_r, pend_r, y_fin;
  logic [MAX_SECTIONS-1:0] cell_busy, cell_start;
  smp_t       cell_y    [MAX_SECTIONS];
  cell_stat_t cell_stat [MAX_SECTIONS];

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign in_stall  = busy_r || pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) section_count_r <= 3'd1;
    else if (cfg_valid && cfg_ready) section_count_r <= cfg_data;
  end

  // clamp the section count; the register keeps what was written
  always_comb begin
    if (section_count_r == 3'd0) last_idx = '0;
    else if (int'(section_count_r) > MAX_SECTIONS) last_idx = SEC_W'(MAX_SECTIONS - 1);
    else last_idx = SEC_W'(int'(section_count_r) - 1);
  end

  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    coef_wr_t wr;
    smp_t     x_in;
    logic     hit;

    assign hit = (int'(in_coef_index) >= i * SLOTS) &&
                 (int'(in_coef_index) < (i + 1) * SLOTS);
    assign wr.en    = in_xfer && in_func && hit;
    assign wr.slot  = coef_slot_t'(3'(int'(in_coef_index) - i * SLOTS));
    assign wr.value = in_coef_value;

    if (i == 0) begin : g_head
      assign cell_start[i] = in_xfer && !in_func;
      assign x_in          = in_sample_in;
    end else begin : g_link
      // a section past the count never starts and keeps its delays
      assign cell_start[i] = cell_stat[i-1].done && (i <= int'(last_idx));
      assign x_in          = cell_y[i-1];
    end

    bq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .coef_wr (wr),
      .start   (cell_start[i]),
      .x       (x_in),
      .y       (cell_y[i]),
      .stat    (cell_stat[i])
    );

    assign cell_busy[i] = cell_stat[i].busy;
  end

  assign fin   = cell_stat[last_idx].done;
  assign y_fin = cell_y[last_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (in_xfer && !in_func) busy_r <= 1'b1;
    else if (fin) busy_r <= 1'b0;
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (fin) begin
      if (out_valid_r && !out_xfer) begin
        pend_r       <= y_fin;
        pend_valid_r <= 1'b1;
      end else begin
        out_r       <= y_fin;
        out_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      if (pend_valid_r) begin
        out_r        <= pend_r;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

`ifndef SYNTH
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n) fin |-> busy_r)
    else $error("result without a sample in flight");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_func) |=> busy_r)
    else $error("sample transfer did not mark the chain busy");
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cell_busy))
    else $error("more than one section working");
`endif

endmodule

>>> tb/sv/biquad_cascade_q31_test.sv
`timescale 1ns / 100ps

module biquad_cascade_q31_test import bq_pkg::*; ();

  localparam int MAXS   = 4;           // matches the default MAX_SECTIONS of the block
  localparam int COEF_N = SLOTS * MAXS;
  localparam int TAIL   = 40;          // one full run through four sections, plus margin
  localparam int HOLD   = 400;         // long receiver hold-off, in cycles

  localparam logic signed [63:0] Q31_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q31_MIN = -64'sd2147483648;

  typedef struct {
    bit         func;
    logic [4:0] idx;
    smp_t       coef;
    smp_t       smp;
  } bq_item_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_func        = 1'b0;
  logic [4:0] in_coef_index  = '0;
  smp_t       in_coef_value  = '0;
  smp_t       in_sample_in   = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  smp_t       out_sample_out;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data       = '0;

  biquad_cascade_q31 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Stimulus waiting to be offered, and filter outputs still to come back.
  bq_item_t pending_items[$];
  smp_t     due_samples[$];

  // Shadow of the block: coefficient words, w1/w2 per section, section register.
  smp_t       coef_tab[COEF_N];
  smp_t       dly[2*MAXS];
  logic [2:0] sec_cnt = 3'd1;

  bit in_took = 1'b0;     // input transfer seen at the last rising edge
  bit calm    = 1'b0;     // no idling on either side while set
  int hold_asks   = 0;    // long hold-offs asked for by the stimulus
  int hold_served = 0;
  int hold_left   = 0;
  int mismatches  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous bound, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL biquad_cascade_q31");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  // Fractional multiply: exact product, floor shift by 31.
  function automatic logic signed [63:0] qmul(input smp_t p, input smp_t q);
    logic signed [63:0] pe, qe;
    pe = p;
    qe = q;
    return (pe * qe) >>> 31;
  endfunction

  function automatic smp_t clamp_q31(input logic signed [63:0] v);
    if (v > Q31_MAX) return smp_t'(Q31_MAX);
    if (v < Q31_MIN) return smp_t'(Q31_MIN);
    return smp_t'(v);
  endfunction

  // Runs one sample through the active sections, updating the shadow delays.
  function automatic smp_t run_cascade(input smp_t x_in);
    int n, b;
    smp_t x, w0, y;
    logic signed [63:0] xe;
    n = (sec_cnt == 0) ? 1 : (sec_cnt > MAXS) ? MAXS : int'(sec_cnt);
    x = x_in;
    for (int s = 0; s < n; s++) begin
      b  = s * SLOTS;
      xe = x;
      w0 = clamp_q31(xe - qmul(coef_tab[b + SLOT_A1], dly[2*s])
                        - qmul(coef_tab[b + SLOT_A2], dly[2*s+1]));
      y  = clamp_q31(qmul(coef_tab[b + SLOT_B0], w0)
                   + qmul(coef_tab[b + SLOT_B1], dly[2*s])
                   + qmul(coef_tab[b + SLOT_B2], dly[2*s+1]));
      dly[2*s+1] = dly[2*s];
      dly[2*s]   = w0;
      x = y;
    end
    return x;
  endfunction

  task automatic report_mismatch(input string what, input smp_t got, input smp_t want);
    if (mismatches < 50)
      $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- driver

  // Offers items at the falling edge; a stalled item is held unchanged
  // until its transfer, and in_valid gets one assignment per step.
  always @(negedge clk) begin
    bq_item_t it;
    if (rst_n) begin
      if (in_valid && !in_took) begin
        // still waiting for its transfer
      end else if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
        it = pending_items.pop_front();
        in_valid      <= 1'b1;
        in_func       <= it.func;
        in_coef_index <= it.idx;
        in_coef_value <= it.coef;
        in_sample_in  <= it.smp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long counted hold-off when one is asked for.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  // ---------------------------------------------------------------- monitor

  // Samples at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    smp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_samples.size() == 0) begin
          report_mismatch("result with nothing due", out_sample_out, '0);
        end else begin
          want = due_samples.pop_front();
          if (out_sample_out !== want)
            report_mismatch("sample_out", out_sample_out, want);
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        if (in_func) begin
          // writes beyond the table are dropped
          if (in_coef_index < COEF_N) coef_tab[in_coef_index] = in_coef_value;
        end else begin
          due_samples.push_back(run_cascade(in_sample_in));
        end
      end
    end else begin
      in_took = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_coef(input int idx, input smp_t v);
    bq_item_t it;
    it.func = 1'b1;
    it.idx  = idx[4:0];
    it.coef = v;
    it.smp  = smp_t'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_sample(input smp_t v);
    bq_item_t it;
    it.func = 1'b0;
    it.idx  = 5'($urandom_range(31));
    it.coef = smp_t'($urandom);
    it.smp  = v;
    pending_items.push_back(it);
  endtask

  // Waits until every item is in and every output has come back, then lets
  // the block finish any trailing coefficient write.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || due_samples.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic set_sections(input logic [2:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sec_cnt = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficient for one slot: full range, or a tame spread so the cascade
  // does not simply sit in saturation.
  function automatic smp_t pick_coef(input bit wild, input int slot);
    if (wild) return smp_t'($urandom);
    if (slot == SLOT_A1) return smp_t'(int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
    if (slot == SLOT_A2) return smp_t'(int'($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
    return smp_t'(int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
  endfunction

  function automatic smp_t pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return smp_t'(Q31_MAX);
    if (r < 16) return smp_t'(Q31_MIN);
    if (r < 40) return smp_t'($urandom) >>> $urandom_range(20);
    return smp_t'($urandom);
  endfunction

  initial begin
    logic [2:0] counts[9];
    bit wild;
    int r;
    counts = '{3'd4, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd6, 3'd1, 3'd4};
    for (int i = 0; i < COEF_N; i++) coef_tab[i] = '0;
    for (int i = 0; i < 2*MAXS; i++) dly[i] = '0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    set_sections(3'd1);

    // Directed: zero coefficients first, then full-scale ones, extremes of
    // the sample, and writes past the end of the table.
    push_sample(smp_t'(Q31_MAX));
    push_coef(SLOT_A1, smp_t'(Q31_MIN));
    push_coef(SLOT_B0, smp_t'(Q31_MAX));
    push_coef(SLOT_B1, smp_t'(Q31_MIN));
    push_coef(SLOT_B2, smp_t'(Q31_MAX));
    push_coef(SLOT_A2, smp_t'(Q31_MAX));
    push_sample(smp_t'(Q31_MAX));
    push_sample(smp_t'(Q31_MAX));
    push_sample(smp_t'(Q31_MIN));
    push_sample(smp_t'(Q31_MIN));
    push_coef(COEF_N, 32'sh1234_5678);
    push_coef(31, -32'sd1);
    push_sample('0);
    push_sample(-32'sd1);
    push_sample(32'sd1);
    drain();

    // Random phases over every register value; sections past the count keep
    // their delays, which the next, wider setting then exposes.
    foreach (counts[p]) begin
      set_sections(counts[p]);
      wild = (p == 1 || p == 5);
      calm = (p == 3);
      if (p == 2) hold_asks++;      // receiver holds off while items keep coming
      for (int i = 0; i < COEF_N; i++) push_coef(i, pick_coef(wild, i % SLOTS));
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(99);
        if (r < 6)       push_coef($urandom_range(COEF_N - 1), pick_coef(wild, $urandom_range(4)));
        else if (r < 9)  push_coef($urandom_range(31), smp_t'($urandom));
        else             push_sample(pick_sample());
      end
      if (p == 6) hold_asks++;
      drain();
    end
    calm = 1'b0;

    if (due_samples.size() != 0)
      report_mismatch("outputs never arrived", '0, smp_t'(due_samples.size()));
    if (mismatches == 0)
      $display("PASS biquad_cascade_q31");
    else
      $display("FAIL biquad_cascade_q31");
    $finish;
  end

endmodule
